// ===== design/multi_channel_period_capture_top_defines.svh =====
// ---------------------------------------------------------------------------
// multi_channel_period_capture_top_defines.svh
// Assertion macros shared by the period capture block.
// ---------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_PERIOD_CAPTURE_TOP_DEFINES_SVH
`define MULTI_CHANNEL_PERIOD_CAPTURE_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset
`define MCPC_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle
`define MCPC_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mcpc_pkg.sv =====
// ---------------------------------------------------------------------------
// mcpc_pkg
// Types and constants of the multi-channel period capture block.
// ---------------------------------------------------------------------------
package mcpc_pkg;

  // Timer and field widths
  localparam int TIMER_BITS = 16;
  localparam int NUM_CH     = 3;
  localparam int CH_W       = 2;
  localparam int LIM_W      = 16;
  localparam int WRAP_W     = 16;
  localparam int TS_W       = 32;
  localparam int PER_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Timer value mask and the first-quarter window for a pending overflow
  localparam logic [63:0] TIMER_MASK  = (64'd1 << TIMER_BITS) - 64'd1;
  localparam logic [63:0] TIMER_QUART = 64'd1 << (TIMER_BITS - 2);

  localparam logic [LIM_W-1:0] LIMIT_RESET = 16'd16;

  // Queue depths (two entries each)
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_CW    = 2;

  // Opcodes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_CAPTURE = 1'b1;

  // Channel codes
  localparam logic [CH_W-1:0] CH_RPM     = 2'd0;
  localparam logic [CH_W-1:0] CH_SPEED   = 2'd1;
  localparam logic [CH_W-1:0] CH_AIRFLOW = 2'd2;
  localparam logic [CH_W-1:0] CH_UNUSED  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RPM_TIMEOUT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AIRFLOW_TIMEOUT = 2'd2;

  typedef struct packed {
    logic                opcode;
    logic [CH_W-1:0]     channel;
    logic [15:0]         capture_value;
    logic                overflow_pending;
  } in_item_t;

  typedef struct packed {
    logic [PER_W-1:0] rpm_period;
    logic [PER_W-1:0] speed_period;
    logic [PER_W-1:0] airflow_period;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_TICK,
    CMD_CAPTURE
  } cmd_kind_t;

  // Classified item handed from the front end to the back end
  typedef struct packed {
    cmd_kind_t       kind;
    logic [CH_W-1:0] ch;
    logic [TS_W-1:0] ts;
  } cmd_t;

  // Back-end handshake status, watched at the top level
  typedef struct packed {
    logic cmd_pop;
    logic res_push;
    logic res_full;
  } back_status_t;

endpackage

// ===== design/mcpc_front.sv =====
// ---------------------------------------------------------------------------
// mcpc_front
// Accepts items, tracks the wrap counter and builds 32-bit timestamps.
// ---------------------------------------------------------------------------
module mcpc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  mcpc_pkg::in_item_t in_item,
  input  logic              in_push,
  output logic              in_full,
  input  logic              q_full,
  output logic              cmd_push,
  output mcpc_pkg::cmd_t    cmd
);
  import mcpc_pkg::*;

  logic [WRAP_W-1:0] wrap_r;
  logic [WRAP_W-1:0] wrap_nxt;
  logic [63:0]       cap_m;
  logic              bump;
  logic [63:0]       wrap_eff;

  // Stall the input side while the command queue is full
  assign in_full  = q_full;
  assign cmd_push = in_push & ~q_full;

  // Extend the capture with the wrap count, adding one wrap for a pending overflow
  always_comb begin
    cap_m    = 64'(in_item.capture_value) & TIMER_MASK;
    bump     = (cap_m < TIMER_QUART) && in_item.overflow_pending;
    wrap_eff = 64'(wrap_r) + 64'(bump);
    cmd.ts   = TS_W'((wrap_eff << TIMER_BITS) | cap_m);
    cmd.ch   = in_item.channel;
    // Classify the item
    unique case (in_item.opcode)
      OP_TICK:    cmd.kind = CMD_TICK;
      OP_CAPTURE: cmd.kind = (in_item.channel == CH_UNUSED) ? CMD_NOP : CMD_CAPTURE;
      default:    cmd.kind = CMD_NOP;
    endcase
  end

  // Advance the wrap counter on every accepted tick
  always_comb begin
    wrap_nxt = wrap_r;
    if (cmd_push && (in_item.opcode == OP_TICK)) begin
      wrap_nxt = WRAP_W'(wrap_r + 16'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r <= '0;
    end else begin
      wrap_r <= wrap_nxt;
    end
  end

endmodule

// ===== design/mcpc_cmd_queue.sv =====
// ---------------------------------------------------------------------------
// mcpc_cmd_queue
// Two-entry queue of classified commands between front and back end.
// ---------------------------------------------------------------------------
module mcpc_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mcpc_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output mcpc_pkg::cmd_t pop_data,
  output logic           empty
);
  import mcpc_pkg::*;

  cmd_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;
  logic                do_push;
  logic                do_pop;

  assign full     = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Hold entries; write at the tail
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= QUEUE_AW'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= QUEUE_AW'(rd_ptr_r + 1'b1);
      end
      count_r <= QUEUE_CW'(count_r + QUEUE_CW'(do_push) - QUEUE_CW'(do_pop));
    end
  end

endmodule

// ===== design/mcpc_back.sv =====
// ---------------------------------------------------------------------------
// mcpc_back
// Updates per-channel period state and queues one result per command.
// ---------------------------------------------------------------------------
module mcpc_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mcpc_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [mcpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  mcpc_pkg::cmd_t                      cmd,
  input  logic                                cmd_empty,
  output logic                                cmd_pop,
  output mcpc_pkg::out_item_t                 out_item,
  output logic                                out_empty,
  input  logic                                out_pop,
  output mcpc_pkg::back_status_t              status
);
  import mcpc_pkg::*;

  logic [LIM_W-1:0]  lim_r   [NUM_CH];
  logic [LIM_W-1:0]  idle_r  [NUM_CH];
  logic [LIM_W-1:0]  idle_nxt[NUM_CH];
  logic [TS_W-1:0]   last_r  [NUM_CH];
  logic [TS_W-1:0]   last_nxt[NUM_CH];
  logic              wait_r  [NUM_CH];
  logic              wait_nxt[NUM_CH];
  logic [PER_W-1:0]  per_r   [NUM_CH];
  logic [PER_W-1:0]  per_nxt [NUM_CH];
  logic [LIM_W-1:0]  idle_inc[NUM_CH];

  out_item_t           res_mem_r [QUEUE_DEPTH];
  out_item_t           res_new;
  logic [QUEUE_AW-1:0] res_wr_r;
  logic [QUEUE_AW-1:0] res_rd_r;
  logic [QUEUE_CW-1:0] res_cnt_r;
  logic                res_full;
  logic                res_pop;

  assign res_full  = (res_cnt_r == QUEUE_CW'(QUEUE_DEPTH));
  assign out_empty = (res_cnt_r == '0);
  assign res_pop   = out_pop & ~out_empty;
  assign out_item  = res_mem_r[res_rd_r];

  // Take a command whenever the result queue has room
  assign cmd_pop = ~cmd_empty & ~res_full;

  assign status.cmd_pop  = cmd_pop;
  assign status.res_push = cmd_pop;
  assign status.res_full = res_full;

  // Per-channel update for a tick or a capture
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      idle_nxt[c] = idle_r[c];
      last_nxt[c] = last_r[c];
      wait_nxt[c] = wait_r[c];
      per_nxt[c]  = per_r[c];
      idle_inc[c] = (idle_r[c] < lim_r[c]) ? LIM_W'(idle_r[c] + 16'd1) : idle_r[c];
      if (cmd_pop) begin
        case (cmd.kind)
          CMD_TICK: begin
            idle_nxt[c] = idle_inc[c];
            if (idle_inc[c] >= lim_r[c]) begin
              per_nxt[c]  = '0;
              last_nxt[c] = '0;
              wait_nxt[c] = 1'b1;
            end
          end
          CMD_CAPTURE: begin
            if (cmd.ch == CH_W'(c)) begin
              if (wait_r[c]) begin
                wait_nxt[c] = 1'b0;
              end else begin
                per_nxt[c] = PER_W'(cmd.ts - last_r[c]);
              end
              last_nxt[c] = cmd.ts;
              idle_nxt[c] = '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Result holds all three periods after the update
  always_comb begin
    res_new.rpm_period     = per_nxt[CH_RPM];
    res_new.speed_period   = per_nxt[CH_SPEED];
    res_new.airflow_period = per_nxt[CH_AIRFLOW];
  end

  // Channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CH; c++) begin
        idle_r[c] <= '0;
        last_r[c] <= '0;
        wait_r[c] <= 1'b1;
        per_r[c]  <= '0;
      end
    end else begin
      for (int c = 0; c < NUM_CH; c++) begin
        idle_r[c] <= idle_nxt[c];
        last_r[c] <= last_nxt[c];
        wait_r[c] <= wait_nxt[c];
        per_r[c]  <= per_nxt[c];
      end
    end
  end

  // Timeout limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CH; c++) begin
        lim_r[c] <= LIMIT_RESET;
      end
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RPM_TIMEOUT:     lim_r[CH_RPM]     <= cfg_wdata;
        REG_SPEED_TIMEOUT:   lim_r[CH_SPEED]   <= cfg_wdata;
        REG_AIRFLOW_TIMEOUT: lim_r[CH_AIRFLOW] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      res_mem_r[res_wr_r] <= res_new;
    end
  end

  // Result queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r  <= '0;
      res_rd_r  <= '0;
      res_cnt_r <= '0;
    end else begin
      if (cmd_pop) begin
        res_wr_r <= QUEUE_AW'(res_wr_r + 1'b1);
      end
      if (res_pop) begin
        res_rd_r <= QUEUE_AW'(res_rd_r + 1'b1);
      end
      res_cnt_r <= QUEUE_CW'(res_cnt_r + QUEUE_CW'(cmd_pop) - QUEUE_CW'(res_pop));
    end
  end

endmodule

// ===== design/multi_channel_period_capture_top.sv =====
// Throughput: one item per cycle while the result queue has room; an item is
// registered in the command queue, then the per-channel subtract and compare
// run once per cycle in the back end; two-entry queues decouple both sides.
// Reset: synchronous, active low; periods clear to zero, channels wait for a
// first edge, wrap counter clears and every timeout limit returns to 16.
// ---------------------------------------------------------------------------
// multi_channel_period_capture_top
// Three-channel input capture period measurement with timeouts.
// ---------------------------------------------------------------------------
`include "multi_channel_period_capture_top_defines.svh"

module multi_channel_period_capture_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  mcpc_pkg::in_item_t               in_item,
  output logic                             out_empty,
  input  logic                             out_pop,
  output mcpc_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  logic [mcpc_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [mcpc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mcpc_pkg::*;

  cmd_t         front_cmd;
  cmd_t         q_cmd;
  logic         front_push;
  logic         q_full;
  logic         q_empty;
  logic         q_pop;
  back_status_t back_st;

  // Accept and classify
  mcpc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .in_push  (in_push),
    .in_full  (in_full),
    .q_full   (q_full),
    .cmd_push (front_push),
    .cmd      (front_cmd)
  );

  // Decouple front and back
  mcpc_cmd_queue u_cmd_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .push_data (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_cmd),
    .empty     (q_empty)
  );

  // Update periods and queue results
  mcpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cmd       (q_cmd),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .status    (back_st)
  );

  // An accepted item is always waiting in the command queue in the next cycle
  `MCPC_CHECK_NEXT(a_push_lands, in_push && !in_full, !q_empty, "accepted item lost")
  // Every command taken by the back end yields exactly one result
  `MCPC_CHECK(a_one_result, back_st.res_push == back_st.cmd_pop, "result count mismatch")
  // The back end never stalls while it has work and room for a result
  `MCPC_CHECK(a_no_stall, (!q_empty && !back_st.res_full) == back_st.cmd_pop, "back end stalled")

endmodule
